[design/ook_pwm_gap_decoder_top_assert.svh]
// Assertion macros for the OOK pulse-width gap decoder
`ifndef OOK_PWM_GAP_DECODER_TOP_ASSERT_SVH
`define OOK_PWM_GAP_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define OPGD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("opgd assertion failed");

// next-cycle implication
`define OPGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("opgd assertion failed");

`endif

[design/opgd_pkg.sv]
// Shared types and constants for the OOK pulse-width gap decoder
`timescale 1ns / 1ps

package opgd_pkg;

    localparam int DUR_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    localparam int EDGE_W = 10;
    localparam int CNT_W  = 10;
    localparam int BIT_W  = 7;
    localparam int CODE_W = 24;

    localparam logic [IDX_W-1:0] REG_SHORT_MIN     = 3'd0;
    localparam logic [IDX_W-1:0] REG_SHORT_MAX     = 3'd1;
    localparam logic [IDX_W-1:0] REG_LONG_LO       = 3'd2;
    localparam logic [IDX_W-1:0] REG_LONG_HI       = 3'd3;
    localparam logic [IDX_W-1:0] REG_SYNC_MIN      = 3'd4;
    localparam logic [IDX_W-1:0] REG_SYNC_MAX      = 3'd5;
    localparam logic [IDX_W-1:0] REG_GAP_RESET_MIN = 3'd6;
    localparam logic [IDX_W-1:0] REG_GAP_RESET_MAX = 3'd7;

    localparam logic [CFG_W-1:0] SHORT_MIN_RST     = 16'd350;
    localparam logic [CFG_W-1:0] SHORT_MAX_RST     = 16'd750;
    localparam logic [CFG_W-1:0] LONG_LO_RST       = 16'd1150;
    localparam logic [CFG_W-1:0] LONG_HI_RST       = 16'd1800;
    localparam logic [CFG_W-1:0] SYNC_MIN_RST      = 16'd3800;
    localparam logic [CFG_W-1:0] SYNC_MAX_RST      = 16'd5200;
    localparam logic [CFG_W-1:0] GAP_RESET_MIN_RST = 16'd7500;
    localparam logic [CFG_W-1:0] GAP_RESET_MAX_RST = 16'd10000;

    localparam logic [DUR_W-1:0] DUR_SATURATED = 16'hFFFF;

    localparam logic [EDGE_W-1:0] EDGE_LIMIT = 10'd512;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 10'd1023;
    localparam logic [BIT_W-1:0]  MAX_BITS   = 7'd64;

    localparam logic [EDGE_W-1:0] EDGES_MIN  = 10'd30;
    localparam logic [EDGE_W-1:0] EDGES_MAX  = 10'd95;
    localparam logic [CNT_W-1:0]  SHORTS_MIN = 10'd18;
    localparam logic [CNT_W-1:0]  LONGS_MIN  = 10'd6;
    localparam logic [BIT_W-1:0]  BITS_MIN   = 7'd24;
    localparam logic [BIT_W-1:0]  BITS_MAX   = 7'd40;

    // queue depth, a power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             last_edge;
    } in_item_t;

    typedef struct packed {
        logic              packet_valid;
        logic [BIT_W-1:0]  bits_decoded;
        logic [CODE_W-1:0] code_low24;
        logic [EDGE_W-1:0] edges_seen;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] short_min;
        logic [CFG_W-1:0] short_max;
        logic [CFG_W-1:0] long_lo;
        logic [CFG_W-1:0] long_hi;
        logic [CFG_W-1:0] sync_min;
        logic [CFG_W-1:0] sync_max;
        logic [CFG_W-1:0] gap_reset_min;
        logic [CFG_W-1:0] gap_reset_max;
    } cfg_t;

    typedef struct packed {
        logic last_edge;
        logic in_short;
        logic in_long;
        logic in_sync;
        logic cls_long;
        logic cls_sync_reset;
    } cls_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[design/opgd_front.sv]
// Front end: configuration registers and edge classifier
`timescale 1ns / 1ps

module opgd_front
    import opgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  in_item_t          item,
    output cls_t              cls
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic in_short;
    logic in_long;
    logic in_sync;
    logic in_reset;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SHORT_MIN:     cfg_next.short_min     = cfg_data;
                REG_SHORT_MAX:     cfg_next.short_max     = cfg_data;
                REG_LONG_LO:       cfg_next.long_lo       = cfg_data;
                REG_LONG_HI:       cfg_next.long_hi       = cfg_data;
                REG_SYNC_MIN:      cfg_next.sync_min      = cfg_data;
                REG_SYNC_MAX:      cfg_next.sync_max      = cfg_data;
                REG_GAP_RESET_MIN: cfg_next.gap_reset_min = cfg_data;
                REG_GAP_RESET_MAX: cfg_next.gap_reset_max = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_min     <= SHORT_MIN_RST;
            cfg_reg.short_max     <= SHORT_MAX_RST;
            cfg_reg.long_lo       <= LONG_LO_RST;
            cfg_reg.long_hi       <= LONG_HI_RST;
            cfg_reg.sync_min      <= SYNC_MIN_RST;
            cfg_reg.sync_max      <= SYNC_MAX_RST;
            cfg_reg.gap_reset_min <= GAP_RESET_MIN_RST;
            cfg_reg.gap_reset_max <= GAP_RESET_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        in_short = (item.duration >= cfg_reg.short_min) && (item.duration <= cfg_reg.short_max);
        in_long  = (item.duration >= cfg_reg.long_lo) && (item.duration <= cfg_reg.long_hi);
        in_sync  = (item.duration >= cfg_reg.sync_min) && (item.duration <= cfg_reg.sync_max);
        in_reset = ((item.duration >= cfg_reg.gap_reset_min)
                    && (item.duration <= cfg_reg.gap_reset_max))
                   || (item.duration == DUR_SATURATED);

        cls.last_edge      = item.last_edge;
        cls.in_short       = in_short;
        cls.in_long        = in_long;
        cls.in_sync        = in_sync;
        cls.cls_long       = in_long && !in_short;
        cls.cls_sync_reset = !in_short && !in_long && (in_sync || in_reset);
    end

endmodule

[design/opgd_queue.sv]
// Short queue of classified edges between front and back end
`timescale 1ns / 1ps

module opgd_queue
    import opgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cls_t      push_data,
    input  logic      pop,
    output cls_t      head,
    output q_status_t status
);

    cls_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);

endmodule

[design/opgd_back.sv]
// Back end: screening counters, pulse/gap bit decoder and result register
`timescale 1ns / 1ps

module opgd_back
    import opgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cls_t      head,
    input  logic      q_empty,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam logic [1:0] PH_HUNT_SYNC  = 2'd0;
    localparam logic [1:0] PH_HUNT_SHORT = 2'd1;
    localparam logic [1:0] PH_DECODE     = 2'd2;
    localparam logic [1:0] PH_STOP       = 2'd3;

    logic [EDGE_W-1:0] edge_reg,    edge_next;
    logic [CNT_W-1:0]  short_reg,   short_next;
    logic [CNT_W-1:0]  long_reg,    long_next;
    logic              sr_seen_reg, sr_seen_next;
    logic [1:0]        phase_reg,   phase_next;
    logic              pending_reg, pending_next;
    logic              failed_reg,  failed_next;
    logic [BIT_W-1:0]  bits_reg,    bits_next;
    logic [CODE_W-1:0] code_reg,    code_next;

    logic              out_valid_reg;
    out_item_t         out_data_reg;
    out_item_t         result;
    logic              emit;

    assign pop  = !q_empty && (!head.last_edge || !out_valid_reg || !out_stall);
    assign emit = pop && head.last_edge;

    always_comb
    begin
        edge_next    = (edge_reg < EDGE_LIMIT) ? edge_reg + EDGE_W'(1) : edge_reg;
        short_next   = (head.in_short && short_reg < CNT_MAX) ? short_reg + CNT_W'(1) : short_reg;
        long_next    = (head.cls_long && long_reg < CNT_MAX) ? long_reg + CNT_W'(1) : long_reg;
        sr_seen_next = sr_seen_reg || head.cls_sync_reset;
        phase_next   = phase_reg;
        pending_next = pending_reg;
        failed_next  = failed_reg;
        bits_next    = bits_reg;
        code_next    = code_reg;

        case (phase_reg)
            PH_HUNT_SYNC:
            begin
                if (head.in_sync)
                begin
                    phase_next = PH_HUNT_SHORT;
                end
            end
            PH_HUNT_SHORT:
            begin
                if (head.in_short)
                begin
                    phase_next = PH_DECODE;
                    if (!head.last_edge)
                    begin
                        pending_next = 1'b1;
                    end
                end
            end
            PH_DECODE:
            begin
                if (!pending_reg)
                begin
                    if (!head.last_edge)
                    begin
                        if (!head.in_short)
                        begin
                            failed_next = 1'b1;
                            phase_next  = PH_STOP;
                        end
                        else
                        begin
                            pending_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    pending_next = 1'b0;
                    if (head.in_short || head.in_long)
                    begin
                        code_next = {code_reg[CODE_W-2:0], !head.in_short};
                        bits_next = bits_reg + BIT_W'(1);
                        if (bits_next >= MAX_BITS)
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    else
                    begin
                        failed_next = 1'b1;
                        phase_next  = PH_STOP;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        result.packet_valid = (edge_next >= EDGES_MIN) && (edge_next <= EDGES_MAX)
                              && (short_next >= SHORTS_MIN) && (long_next >= LONGS_MIN)
                              && sr_seen_next && !failed_next
                              && (bits_next >= BITS_MIN) && (bits_next <= BITS_MAX);
        result.bits_decoded = bits_next;
        result.code_low24   = code_next;
        result.edges_seen   = edge_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg    <= '0;
            short_reg   <= '0;
            long_reg    <= '0;
            sr_seen_reg <= 1'b0;
            phase_reg   <= PH_HUNT_SYNC;
            pending_reg <= 1'b0;
            failed_reg  <= 1'b0;
            bits_reg    <= '0;
            code_reg    <= '0;
        end
        else if (pop)
        begin
            if (head.last_edge)
            begin
                edge_reg    <= '0;
                short_reg   <= '0;
                long_reg    <= '0;
                sr_seen_reg <= 1'b0;
                phase_reg   <= PH_HUNT_SYNC;
                pending_reg <= 1'b0;
                failed_reg  <= 1'b0;
                bits_reg    <= '0;
                code_reg    <= '0;
            end
            else
            begin
                edge_reg    <= edge_next;
                short_reg   <= short_next;
                long_reg    <= long_next;
                sr_seen_reg <= sr_seen_next;
                phase_reg   <= phase_next;
                pending_reg <= pending_next;
                failed_reg  <= failed_next;
                bits_reg    <= bits_next;
                code_reg    <= code_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[design/ook_pwm_gap_decoder_top.sv]
// Top level of the OOK pulse-width gap decoder
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   in_data (duration, last_edge)
//   out       output     out_valid / out_stall out_data (valid, bits, code, edges)
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// One edge item per cycle while in_stall is low: classify as the item enters the queue,
// update decoder state as it leaves, at the earliest on the edge after acceptance.
// A last_edge item's result shows on out_valid right after that edge.
// A two-entry queue lets the front keep accepting while a result waits on out_stall;
// in_stall rises only once the queue fills behind a held result.
// Reset restores the default ranges and clears all decoder state.
`timescale 1ns / 1ps

`include "ook_pwm_gap_decoder_top_assert.svh"

module ook_pwm_gap_decoder_top
    import opgd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data
);

    cls_t      front_cls;
    cls_t      q_head;
    q_status_t q_status;
    logic      push;
    logic      pop;

    assign in_stall = q_status.full;
    assign push     = in_valid && !in_stall;

    opgd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_data),
        .cls       (front_cls)
    );

    opgd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cls),
        .pop       (pop),
        .head      (q_head),
        .status    (q_status)
    );

    opgd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_status.empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `OPGD_ASSERT_IMP(a_no_pop_empty, pop, !q_status.empty)
    `OPGD_ASSERT_IMP(a_valid_bits_range, out_valid && out_data.packet_valid,
        out_data.bits_decoded >= BITS_MIN && out_data.bits_decoded <= BITS_MAX)
    `OPGD_ASSERT_IMP(a_edges_sat, out_valid, out_data.edges_seen <= EDGE_LIMIT)
    `OPGD_ASSERT_NEXT(a_push_count, push && !pop && !q_status.full, !q_status.empty)

endmodule

[verif/ook_pwm_gap_decoder_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the OOK pulse-width gap decoder: directed table, random captures
module ook_pwm_gap_decoder_top_tb;
    import opgd_pkg::*;

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_ITEMS    = 12;
    localparam int LONG_EDGES     = 520;
    localparam int FILL_ITEMS     = 8;

    typedef enum logic [1:0] {HUNT_SYNC, HUNT_SHORT, DECODING, STOPPED} decode_phase_e;

    typedef struct packed {
        logic [DUR_W-1:0] dur;
        logic             last;
        logic             typed;
        out_item_t        res;
    } edge_row_t;

    localparam out_item_t NO_RESULT = '0;

    localparam cfg_t DEFAULT_RANGES = '{SHORT_MIN_RST, SHORT_MAX_RST, LONG_LO_RST, LONG_HI_RST,
        SYNC_MIN_RST, SYNC_MAX_RST, GAP_RESET_MIN_RST, GAP_RESET_MAX_RST};
    localparam cfg_t OVERLAP_RANGES = '{16'd0, 16'd800, 16'd600, 16'd2000,
        16'd700, 16'd5000, 16'd5001, 16'd65534};
    localparam cfg_t EMPTY_RANGES = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0,
        16'hFFFF, 16'd0, 16'hFFFF, 16'd0};

    localparam edge_row_t DIRECTED_ROWS [25] = '{
        '{16'd0,     1'b1, 1'b1, '{1'b0, 7'd0, 24'd0, 10'd1}},
        '{16'd65535, 1'b1, 1'b1, '{1'b0, 7'd0, 24'd0, 10'd1}},
        '{16'd4000,  1'b0, 1'b0, NO_RESULT},
        '{16'd500,   1'b0, 1'b0, NO_RESULT},
        '{16'd1500,  1'b0, 1'b0, NO_RESULT},
        '{16'd500,   1'b0, 1'b0, NO_RESULT},
        '{16'd500,   1'b0, 1'b0, NO_RESULT},
        '{16'd500,   1'b0, 1'b0, NO_RESULT},
        '{16'd3000,  1'b0, 1'b0, NO_RESULT},
        '{16'd500,   1'b1, 1'b0, NO_RESULT},
        '{16'd4000,  1'b0, 1'b0, NO_RESULT},
        '{16'd500,   1'b0, 1'b0, NO_RESULT},
        '{16'd1500,  1'b0, 1'b0, NO_RESULT},
        '{16'd500,   1'b1, 1'b0, NO_RESULT},
        '{16'd5200,  1'b0, 1'b0, NO_RESULT},
        '{16'd350,   1'b0, 1'b0, NO_RESULT},
        '{16'd750,   1'b0, 1'b0, NO_RESULT},
        '{16'd1800,  1'b0, 1'b0, NO_RESULT},
        '{16'd350,   1'b1, 1'b0, NO_RESULT},
        '{16'd500,   1'b0, 1'b0, NO_RESULT},
        '{16'd1150,  1'b0, 1'b0, NO_RESULT},
        '{16'd500,   1'b1, 1'b1, '{1'b0, 7'd0, 24'd0, 10'd3}},
        '{16'd3800,  1'b0, 1'b0, NO_RESULT},
        '{16'd750,   1'b1, 1'b1, '{1'b0, 7'd0, 24'd0, 10'd2}},
        '{16'd10000, 1'b1, 1'b1, '{1'b0, 7'd0, 24'd0, 10'd1}}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;

    // decoder image
    cfg_t              ranges;
    logic [EDGE_W-1:0] edge_cnt;
    logic [CNT_W-1:0]  short_cnt;
    logic [CNT_W-1:0]  long_cnt;
    logic              sync_seen;
    decode_phase_e     phase;
    logic              pulse_pending;
    logic              decode_failed;
    logic [BIT_W-1:0]  bit_cnt;
    logic [CODE_W-1:0] code;

    out_item_t expected_results [$];
    logic      row_typed;
    out_item_t row_result;
    bit        steady;
    bit        hold_out;
    int        n_errors;
    int        results_checked;
    int        valid_packets;
    int        edges_sent;
    int        settings_used;
    int        quiet_cycles;

    ook_pwm_gap_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit between(input logic [DUR_W-1:0] v, input logic [DUR_W-1:0] lo,
                                   input logic [DUR_W-1:0] hi);
        return v >= lo && v <= hi;
    endfunction

    function automatic logic [DUR_W-1:0] pick(input logic [DUR_W-1:0] lo,
                                              input logic [DUR_W-1:0] hi);
        if (lo <= hi)
        begin
            return DUR_W'($urandom_range(hi, lo));
        end
        return DUR_W'($urandom);
    endfunction

    function automatic cfg_t ascending_ranges();
        cfg_t c;
        c.short_min     = CFG_W'($urandom_range(0, 400));
        c.short_max     = CFG_W'(c.short_min + $urandom_range(50, 600));
        c.long_lo       = CFG_W'(c.short_max + $urandom_range(1, 400));
        c.long_hi       = CFG_W'(c.long_lo + $urandom_range(100, 1000));
        c.sync_min      = CFG_W'(c.long_hi + $urandom_range(1, 2000));
        c.sync_max      = CFG_W'(c.sync_min + $urandom_range(100, 2000));
        c.gap_reset_min = CFG_W'(c.sync_max + $urandom_range(1, 3000));
        c.gap_reset_max = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                        : CFG_W'(c.gap_reset_min + $urandom_range(100, 5000));
        return c;
    endfunction

    task automatic clear_capture();
        edge_cnt      = '0;
        short_cnt     = '0;
        long_cnt      = '0;
        sync_seen     = 1'b0;
        phase         = HUNT_SYNC;
        pulse_pending = 1'b0;
        decode_failed = 1'b0;
        bit_cnt       = '0;
        code          = '0;
    endtask

    task automatic predict_edge(input in_item_t e, output bit produced, output out_item_t res);
        logic [DUR_W-1:0] d;
        bit is_short;
        bit in_long;
        bit in_sync;
        bit cls_reset;
        d         = e.duration;
        is_short  = between(d, ranges.short_min, ranges.short_max);
        in_long   = between(d, ranges.long_lo, ranges.long_hi);
        in_sync   = between(d, ranges.sync_min, ranges.sync_max);
        cls_reset = between(d, ranges.gap_reset_min, ranges.gap_reset_max) || d == DUR_SATURATED;
        if (edge_cnt < EDGE_LIMIT)
            edge_cnt++;
        if (is_short && short_cnt < CNT_MAX)
            short_cnt++;
        if (!is_short && in_long && long_cnt < CNT_MAX)
            long_cnt++;
        if (!is_short && !in_long && (in_sync || cls_reset))
            sync_seen = 1'b1;
        case (phase)
            HUNT_SYNC:
            begin
                if (in_sync)
                    phase = HUNT_SHORT;
            end
            HUNT_SHORT:
            begin
                if (is_short)
                begin
                    phase         = DECODING;
                    pulse_pending = !e.last_edge;
                end
            end
            DECODING:
            begin
                if (!pulse_pending)
                begin
                    if (!e.last_edge)
                    begin
                        if (is_short)
                        begin
                            pulse_pending = 1'b1;
                        end
                        else
                        begin
                            decode_failed = 1'b1;
                            phase         = STOPPED;
                        end
                    end
                end
                else
                begin
                    pulse_pending = 1'b0;
                    if (is_short || in_long)
                    begin
                        code = {code[CODE_W-2:0], !is_short};
                        bit_cnt++;
                        if (bit_cnt >= MAX_BITS)
                            phase = STOPPED;
                    end
                    else
                    begin
                        decode_failed = 1'b1;
                        phase         = STOPPED;
                    end
                end
            end
            default:
            begin
            end
        endcase
        produced = e.last_edge;
        res      = NO_RESULT;
        if (e.last_edge)
        begin
            res.packet_valid = edge_cnt >= EDGES_MIN && edge_cnt <= EDGES_MAX
                && short_cnt >= SHORTS_MIN && long_cnt >= LONGS_MIN && sync_seen
                && !decode_failed && bit_cnt >= BITS_MIN && bit_cnt <= BITS_MAX;
            res.bits_decoded = bit_cnt;
            res.code_low24   = code;
            res.edges_seen   = edge_cnt;
            clear_capture();
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: valid %0d bits %0d code %h edges %0d",
                got.packet_valid, got.bits_decoded, got.code_low24, got.edges_seen);
            n_errors++;
        end
        else
        begin
            want = expected_results.pop_front();
            results_checked++;
            if (got.packet_valid !== want.packet_valid)
            begin
                $error("packet_valid: expected %0d, got %0d", want.packet_valid, got.packet_valid);
                n_errors++;
            end
            if (got.bits_decoded !== want.bits_decoded)
            begin
                $error("bits_decoded: expected %0d, got %0d", want.bits_decoded, got.bits_decoded);
                n_errors++;
            end
            if (got.code_low24 !== want.code_low24)
            begin
                $error("code_low24: expected %h, got %h", want.code_low24, got.code_low24);
                n_errors++;
            end
            if (got.edges_seen !== want.edges_seen)
            begin
                $error("edges_seen: expected %0d, got %0d", want.edges_seen, got.edges_seen);
                n_errors++;
            end
            if (want.packet_valid && got.packet_valid === 1'b1)
                valid_packets++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        bit        produced;
        out_item_t predicted;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result(out_data);
            if (in_valid && !in_stall)
            begin
                predict_edge(in_data, produced, predicted);
                if (produced)
                    expected_results.push_back(row_typed ? row_result : predicted);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("ook_pwm_gap_decoder_top_tb: errors");
            $finish;
        end
    end

    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = steady ? 0 : $urandom_range(0, 3);
            if (hold_out)
            begin
                hold_out = 1'b0;
                n        = HOLD_CYCLES;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_edge(input logic [DUR_W-1:0] d, input logic last,
                             input logic typed, input out_item_t res);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_data    <= '{duration: d, last_edge: last};
        row_typed  <= typed;
        row_result <= res;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        edges_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_SHORT_MIN:     ranges.short_min     = val;
            REG_SHORT_MAX:     ranges.short_max     = val;
            REG_LONG_LO:       ranges.long_lo       = val;
            REG_LONG_HI:       ranges.long_hi       = val;
            REG_SYNC_MIN:      ranges.sync_min      = val;
            REG_SYNC_MAX:      ranges.sync_max      = val;
            REG_GAP_RESET_MIN: ranges.gap_reset_min = val;
            REG_GAP_RESET_MAX: ranges.gap_reset_max = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic program_ranges(input cfg_t c);
        drain();
        write_reg(REG_SHORT_MIN, c.short_min);
        write_reg(REG_SHORT_MAX, c.short_max);
        write_reg(REG_LONG_LO, c.long_lo);
        write_reg(REG_LONG_HI, c.long_hi);
        write_reg(REG_SYNC_MIN, c.sync_min);
        write_reg(REG_SYNC_MAX, c.sync_max);
        write_reg(REG_GAP_RESET_MIN, c.gap_reset_min);
        write_reg(REG_GAP_RESET_MAX, c.gap_reset_max);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic logic [DUR_W-1:0] any_class();
        case ($urandom_range(0, 4))
            0:       return DUR_W'($urandom);
            1:       return pick(ranges.short_min, ranges.short_max);
            2:       return pick(ranges.long_lo, ranges.long_hi);
            3:       return pick(ranges.sync_min, ranges.sync_max);
            default: return pick(ranges.gap_reset_min, ranges.gap_reset_max);
        endcase
    endfunction

    task automatic send_noise_capture();
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            send_edge(any_class(), i == len - 1, 1'b0, NO_RESULT);
    endtask

    task automatic send_packet();
        int               nbits;
        int               corrupt;
        int               sel;
        logic [DUR_W-1:0] d;
        repeat ($urandom_range(0, 3)) send_edge(any_class(), 1'b0, 1'b0, NO_RESULT);
        if ($urandom_range(0, 3) == 0)
            send_edge($urandom_range(0, 1) ? DUR_SATURATED
                      : pick(ranges.gap_reset_min, ranges.gap_reset_max), 1'b0, 1'b0, NO_RESULT);
        send_edge(pick(ranges.sync_min, ranges.sync_max), 1'b0, 1'b0, NO_RESULT);
        sel   = $urandom_range(0, 9);
        nbits = (sel == 0) ? $urandom_range(60, 70) : (sel == 1) ? $urandom_range(2, 23)
              : $urandom_range(22, 42);
        corrupt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2 * nbits - 1) : -1;
        for (int i = 0; i < 2 * nbits; i++)
        begin
            if (i % 2 == 0 || $urandom_range(0, 1))
                d = pick(ranges.short_min, ranges.short_max);
            else
                d = pick(ranges.long_lo, ranges.long_hi);
            if (i == corrupt)
                d = DUR_W'($urandom);
            send_edge(d, 1'b0, 1'b0, NO_RESULT);
        end
        send_edge($urandom_range(0, 1) ? pick(ranges.short_min, ranges.short_max)
                  : DUR_W'($urandom), 1'b1, 1'b0, NO_RESULT);
    endtask

    task automatic send_long_capture();
        logic [DUR_W-1:0] d;
        send_edge(pick(ranges.sync_min, ranges.sync_max), 1'b0, 1'b0, NO_RESULT);
        for (int i = 0; i < LONG_EDGES; i++)
        begin
            if (i < 128 && i % 2 == 1 && $urandom_range(0, 1))
                d = pick(ranges.long_lo, ranges.long_hi);
            else
                d = pick(ranges.short_min, ranges.short_max);
            send_edge(d, i == LONG_EDGES - 1, 1'b0, NO_RESULT);
        end
    endtask

    initial
    begin : stimulus
        int phase_start;
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_SHORT_MIN;
        cfg_data        = '0;
        in_valid        = 1'b0;
        in_data         = '0;
        row_typed       = 1'b0;
        row_result      = NO_RESULT;
        steady          = 1'b0;
        hold_out        = 1'b0;
        n_errors        = 0;
        results_checked = 0;
        valid_packets   = 0;
        edges_sent      = 0;
        settings_used   = 1;
        ranges          = DEFAULT_RANGES;
        clear_capture();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_edge(DIRECTED_ROWS[i].dur, DIRECTED_ROWS[i].last,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
        drain();
        send_long_capture();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1:       program_ranges(ascending_ranges());
                2:       program_ranges(OVERLAP_RANGES);
                3:       program_ranges(EMPTY_RANGES);
                4:       program_ranges(ascending_ranges());
                default: drain();
            endcase
            if (ph == 1)
            begin
                // fill the edge queue behind a held result while the receiver holds off
                steady   = 1'b1;
                hold_out = 1'b1;
                repeat (FILL_ITEMS) send_edge(DUR_W'($urandom), 1'b1, 1'b0, NO_RESULT);
                drain();
            end
            phase_start = edges_sent;
            while (edges_sent - phase_start < PHASE_ITEMS)
            begin
                steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) < 7)
                    send_packet();
                else
                    send_noise_capture();
            end
        end
        steady = 1'b0;
        drain();

        $display("covered %0d edge items over %0d range settings", edges_sent, settings_used);
        $display("compared %0d results, %0d of them valid packets", results_checked,
                 valid_packets);
        if (n_errors == 0)
            $display("ook_pwm_gap_decoder_top_tb: clean");
        else
            $display("ook_pwm_gap_decoder_top_tb: errors");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/opgd_pkg.sv
design/opgd_front.sv
design/opgd_queue.sv
design/opgd_back.sv
design/ook_pwm_gap_decoder_top.sv
verif/ook_pwm_gap_decoder_top_tb.sv
